>>> sv/dqcpi_pkg.sv
package dqcpi_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int GAIN_WIDTH = 32;
  localparam int LIM_WIDTH  = 31;
  localparam int PROD_WIDTH = 64;
  localparam int ROOT_STEPS = 32;
  localparam int DIV_STEPS  = 62;
  localparam int CNT_WIDTH  = 6;

  localparam logic REG_PROP_GAIN       = 1'b0;
  localparam logic REG_INTEG_STEP_GAIN = 1'b1;

  localparam logic [GAIN_WIDTH-1:0] PROP_GAIN_RESET  = 32'd65536;
  localparam logic [GAIN_WIDTH-1:0] INTEG_GAIN_RESET = 32'd655;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_PD, OP_PQ, OP_ID, OP_IQ, OP_INTQ, OP_CLAMP, OP_SUM,
    OP_SQD, OP_SQQ, OP_SQL, OP_TEST, OP_SQRT, OP_MOD, OP_MOQ, OP_DVQ, OP_DIV
  } op_t;

  typedef struct packed {
    op_t  op;
    logic load;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic lim_hit;
  } status_t;

  // Saturate a 34-bit signed sum to 32 bits.
  function automatic logic [31:0] sat34(input logic [33:0] v);
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) return v[31:0];
    else if (v[33]) return 32'h8000_0000;
    else return 32'h7FFF_FFFF;
  endfunction

  // Drop fraction bits of an unsigned product, saturate, apply sign.
  function automatic logic [31:0] mulq_fix(input logic [PROD_WIDTH-1:0] p, input logic neg);
    logic [PROD_WIDTH-FRAC_BITS-1:0] q;
    logic [31:0] m;
    q = p[PROD_WIDTH-1:FRAC_BITS];
    m = {1'b0, q[30:0]};
    if (q[PROD_WIDTH-FRAC_BITS-1:31] != '0) return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else return neg ? 32'(-m) : m;
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] a);
    return a[31] ? 32'(-a) : a;
  endfunction

endpackage

>>> sv/dq_current_pi_with_voltage_limit.sv
// A clear word zeroes both integrators; a step runs the PI update and the limit
// test, and a step that is scaled onto the limit then runs a 32-step square
// root and a 62-step shift-subtract division on both axes at once.
// Throughput: one word at a time; the next word is taken once the result is
// handed to the output register. Reset sets gains to 1.0 and 655/65536,
// zeroes both integrators and empties the output register.
module dq_current_pi_with_voltage_limit import dqcpi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  command,
  input  logic [DATA_WIDTH-1:0] err_d,
  input  logic [DATA_WIDTH-1:0] err_q,
  input  logic [DATA_WIDTH-1:0] bemf_d,
  input  logic [DATA_WIDTH-1:0] bemf_q,
  input  logic [LIM_WIDTH-1:0]  volt_limit,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_WIDTH-1:0] volt_d,
  output logic [DATA_WIDTH-1:0] volt_q,
  output logic                  limited,
  input  logic                  wr_en,
  input  logic                  wr_index,
  input  logic [GAIN_WIDTH-1:0] wr_data
);

  cmd_t    cmd;
  status_t status;

  dqcpi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .command   (command),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  dqcpi_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .command    (command),
    .err_d      (err_d),
    .err_q      (err_q),
    .bemf_d     (bemf_d),
    .bemf_q     (bemf_q),
    .volt_limit (volt_limit),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .volt_d     (volt_d),
    .volt_q     (volt_q),
    .limited    (limited)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a word is in work");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("result loaded over a waiting word");

  a_div_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_DIV |-> in_stall)
    else $error("division running while input is open");

endmodule

>>> sv/dqcpi_ctrl.sv
module dqcpi_ctrl import dqcpi_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    command,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [18:0] {
    S_IDLE  = 19'h00001,
    S_CLEAR = 19'h00002,
    S_PD    = 19'h00004,
    S_PQ    = 19'h00008,
    S_ID    = 19'h00010,
    S_IQ    = 19'h00020,
    S_INTQ  = 19'h00040,
    S_CLAMP = 19'h00080,
    S_SUM   = 19'h00100,
    S_SQD   = 19'h00200,
    S_SQQ   = 19'h00400,
    S_SQL   = 19'h00800,
    S_TEST  = 19'h01000,
    S_SQRT  = 19'h02000,
    S_MOD   = 19'h04000,
    S_MOQ   = 19'h08000,
    S_DVQ   = 19'h10000,
    S_DIV   = 19'h20000,
    S_DONE  = 19'h40000
  } state_t;

  state_t state, state_next;
  logic [CNT_WIDTH-1:0] cnt, cnt_next;
  logic in_acc, out_free;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && (state == S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    cmd.op       = OP_NONE;
    cmd.load     = in_acc;
    cmd.out_load = 1'b0;
    case (state)
      S_IDLE:  if (in_acc) state_next = command ? S_CLEAR : S_PD;
      S_CLEAR: begin cmd.op = OP_CLEAR; state_next = S_DONE; end
      S_PD:    begin cmd.op = OP_PD;    state_next = S_PQ;   end
      S_PQ:    begin cmd.op = OP_PQ;    state_next = S_ID;   end
      S_ID:    begin cmd.op = OP_ID;    state_next = S_IQ;   end
      S_IQ:    begin cmd.op = OP_IQ;    state_next = S_INTQ; end
      S_INTQ:  begin cmd.op = OP_INTQ;  state_next = S_CLAMP; end
      S_CLAMP: begin cmd.op = OP_CLAMP; state_next = S_SUM;  end
      S_SUM:   begin cmd.op = OP_SUM;   state_next = S_SQD;  end
      S_SQD:   begin cmd.op = OP_SQD;   state_next = S_SQQ;  end
      S_SQQ:   begin cmd.op = OP_SQQ;   state_next = S_SQL;  end
      S_SQL:   begin cmd.op = OP_SQL;   state_next = S_TEST; end
      S_TEST: begin
        cmd.op   = OP_TEST;
        cnt_next = '0;
        state_next = status.lim_hit ? S_SQRT : S_DONE;
      end
      S_SQRT: begin
        cmd.op   = OP_SQRT;
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_WIDTH'(ROOT_STEPS - 1)) state_next = S_MOD;
      end
      S_MOD: begin cmd.op = OP_MOD; state_next = S_MOQ; end
      S_MOQ: begin cmd.op = OP_MOQ; state_next = S_DVQ; end
      S_DVQ: begin cmd.op = OP_DVQ; cnt_next = '0; state_next = S_DIV; end
      S_DIV: begin
        cmd.op   = OP_DIV;
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_WIDTH'(DIV_STEPS - 1)) state_next = S_DONE;
      end
      S_DONE: begin
        // hold until the output word is free
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule

>>> sv/dqcpi_dp.sv
module dqcpi_dp import dqcpi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic                  command,
  input  logic [DATA_WIDTH-1:0] err_d,
  input  logic [DATA_WIDTH-1:0] err_q,
  input  logic [DATA_WIDTH-1:0] bemf_d,
  input  logic [DATA_WIDTH-1:0] bemf_q,
  input  logic [LIM_WIDTH-1:0]  volt_limit,
  input  logic                  wr_en,
  input  logic                  wr_index,
  input  logic [GAIN_WIDTH-1:0] wr_data,
  output logic [DATA_WIDTH-1:0] volt_d,
  output logic [DATA_WIDTH-1:0] volt_q,
  output logic                  limited
);

  logic [GAIN_WIDTH-1:0] kp, ki;
  logic signed [31:0] integ_d, integ_q;
  logic [31:0] ed, eq, bd, bq, pd, pq, vd_r, vq_r;
  logic [30:0] lim, md, mq;
  logic res_clear, over, lim_flag;
  logic [PROD_WIDTH-1:0] prod;
  logic [62:0] acc;
  logic [63:0] sx;
  logic [33:0] srem;
  logic [31:0] root;
  logic [61:0] dvd_d, dvd_q;
  logic [31:0] rem_d, rem_q;

  logic [31:0] mul_a, mul_b;
  logic [31:0] inc_d, inc_q;

  // clamp bounds for the q integrator
  logic [33:0] lim_s, pq_s, bq_s, lo_raw, hi_raw;
  logic signed [31:0] lo_sat, hi_sat, lo_c, hi_c, q_min, q_cl;
  logic pq_pos;

  logic [31:0] vd_s, vq_s, md_full, mq_full;
  logic over_now;

  logic [35:0] r2, trial;
  logic [31:0] divisor;
  logic [32:0] rsh_d, rsh_q;
  logic ge_d, ge_q;
  logic [31:0] od, oq;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_PD:  begin mul_a = mag32(ed); mul_b = kp; end
      OP_PQ:  begin mul_a = mag32(eq); mul_b = kp; end
      OP_ID:  begin mul_a = mag32(pd); mul_b = ki; end
      OP_IQ:  begin mul_a = mag32(pq); mul_b = ki; end
      OP_SQD: begin mul_a = {1'b0, md}; mul_b = {1'b0, md}; end
      OP_SQQ: begin mul_a = {1'b0, mq}; mul_b = {1'b0, mq}; end
      OP_SQL: begin mul_a = {1'b0, lim}; mul_b = {1'b0, lim}; end
      OP_MOD: begin mul_a = {1'b0, md}; mul_b = {1'b0, lim}; end
      OP_MOQ: begin mul_a = {1'b0, mq}; mul_b = {1'b0, lim}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign inc_d = mulq_fix(prod, pd[31]);
  assign inc_q = mulq_fix(prod, pq[31]);

  always_comb begin
    lim_s  = {3'b000, lim};
    pq_s   = {{2{pq[31]}}, pq};
    bq_s   = {{2{bq[31]}}, bq};
    pq_pos = !pq[31] && (pq != '0);
    lo_raw = pq_pos ? 34'(-lim_s + pq_s - bq_s) : 34'(-lim_s - pq_s - bq_s);
    hi_raw = pq_pos ? 34'(lim_s - pq_s - bq_s) : 34'(lim_s + pq_s - bq_s);
    lo_sat = sat34(lo_raw);
    hi_sat = sat34(hi_raw);
    lo_c   = lo_sat[31] ? lo_sat : 32'sd0;
    hi_c   = hi_sat[31] ? 32'sd0 : hi_sat;
    q_min  = (integ_q > hi_c) ? hi_c : integ_q;
    q_cl   = (q_min < lo_c) ? lo_c : q_min;
  end

  always_comb begin
    vd_s = sat34(34'({{2{pd[31]}}, pd} + {{2{bd[31]}}, bd}
                     + {{2{integ_d[31]}}, integ_d}));
    vq_s = sat34(34'({{2{pq[31]}}, pq} + {{2{bq[31]}}, bq}
                     + {{2{integ_q[31]}}, integ_q}));
    md_full  = mag32(vd_s);
    mq_full  = mag32(vq_s);
    over_now = md_full[31] || mq_full[31];
  end

  assign status.lim_hit = over || ({1'b0, acc} > prod);

  // one root bit per step: bring down two radicand bits
  assign r2    = {srem, sx[63:62]};
  assign trial = {2'b00, root, 2'b01};

  assign divisor = (root == '0) ? 32'd1 : root;
  assign rsh_d   = {rem_d, dvd_d[61]};
  assign rsh_q   = {rem_q, dvd_q[61]};
  assign ge_d    = rsh_d >= {1'b0, divisor};
  assign ge_q    = rsh_q >= {1'b0, divisor};

  assign od = {1'b0, dvd_d[30:0]};
  assign oq = {1'b0, dvd_q[30:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      kp      <= PROP_GAIN_RESET;
      ki      <= INTEG_GAIN_RESET;
      integ_d <= '0;
      integ_q <= '0;
    end else begin
      if (wr_en) begin
        if (wr_index == REG_PROP_GAIN) kp <= wr_data;
        if (wr_index == REG_INTEG_STEP_GAIN) ki <= wr_data;
      end
      case (cmd.op)
        OP_CLEAR: begin integ_d <= '0; integ_q <= '0; end
        OP_IQ:    integ_d <= sat34(34'({{2{integ_d[31]}}, integ_d}
                                   + {{2{inc_d[31]}}, inc_d}));
        OP_INTQ:  integ_q <= sat34(34'({{2{integ_q[31]}}, integ_q}
                                   + {{2{inc_q[31]}}, inc_q}));
        OP_CLAMP: integ_q <= q_cl;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);
    if (cmd.load) begin
      res_clear <= command;
      lim_flag  <= 1'b0;
      ed  <= err_d;
      eq  <= err_q;
      bd  <= bemf_d;
      bq  <= bemf_q;
      lim <= volt_limit;
    end
    case (cmd.op)
      OP_PQ: pd <= mulq_fix(prod, ed[31]);
      OP_ID: pq <= mulq_fix(prod, eq[31]);
      OP_SUM: begin
        vd_r <= vd_s;
        vq_r <= vq_s;
        over <= over_now;
        md   <= over_now ? md_full[31:1] : md_full[30:0];
        mq   <= over_now ? mq_full[31:1] : mq_full[30:0];
      end
      OP_SQQ: acc <= prod[62:0];
      OP_SQL: acc <= acc + prod[62:0];
      OP_TEST: begin
        lim_flag <= status.lim_hit;
        sx   <= {1'b0, acc};
        srem <= '0;
        root <= '0;
      end
      OP_SQRT: begin
        sx <= {sx[61:0], 2'b00};
        if (r2 >= trial) begin
          srem <= 34'(r2 - trial);
          root <= {root[30:0], 1'b1};
        end else begin
          srem <= r2[33:0];
          root <= {root[30:0], 1'b0};
        end
      end
      OP_MOQ: begin dvd_d <= prod[61:0]; rem_d <= '0; end
      OP_DVQ: begin dvd_q <= prod[61:0]; rem_q <= '0; end
      OP_DIV: begin
        rem_d <= ge_d ? 32'(rsh_d - {1'b0, divisor}) : rsh_d[31:0];
        rem_q <= ge_q ? 32'(rsh_q - {1'b0, divisor}) : rsh_q[31:0];
        dvd_d <= {dvd_d[60:0], ge_d};
        dvd_q <= {dvd_q[60:0], ge_q};
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      if (res_clear) begin
        volt_d  <= '0;
        volt_q  <= '0;
        limited <= 1'b0;
      end else if (lim_flag) begin
        volt_d  <= vd_r[31] ? 32'(-od) : od;
        volt_q  <= vq_r[31] ? 32'(-oq) : oq;
        limited <= 1'b1;
      end else begin
        volt_d  <= vd_r;
        volt_q  <= vq_r;
        limited <= 1'b0;
      end
    end
  end

endmodule

>>> sim/tb_dq_current_pi_with_voltage_limit.sv
`timescale 1ns / 1ps

module tb_dq_current_pi_with_voltage_limit;
  import dqcpi_pkg::*;

  localparam int  IDLE_LIMIT = 20000;
  localparam int  SETTLE     = 150;
  localparam logic CMD_STEP  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic        command;
    logic [31:0] err_d;
    logic [31:0] err_q;
    logic [31:0] bemf_d;
    logic [31:0] bemf_q;
    logic [30:0] volt_limit;
  } ctl_word_t;

  typedef struct packed {
    logic [31:0] volt_d;
    logic [31:0] volt_q;
    logic        limited;
  } volt_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        command = 1'b0;
  logic [31:0] err_d = '0, err_q = '0, bemf_d = '0, bemf_q = '0;
  logic [30:0] volt_limit = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] volt_d, volt_q;
  logic        limited;
  logic        wr_en = 1'b0;
  logic        wr_index = 1'b0;
  logic [31:0] wr_data = '0;

  ctl_word_t  pending_q[$];
  volt_word_t expected_volts[$];

  // predictor state
  longint unsigned kp, ki;
  longint          acc_d, acc_q;

  int  errors = 0;
  int  sent = 0, offered = 0, checked = 0, limited_seen = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;       // no random idling near the end
  bit  hold_sender = 1'b0;
  bit  long_hold_req = 1'b0;
  int  in_gap = 0, out_gap = 0, long_hold = 0;

  always #5 clk = ~clk;

  dq_current_pi_with_voltage_limit u_top (.*);

  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;

  function automatic longint clip(input longint v);
    if (v > VMAX) return VMAX;
    if (v < VMIN) return VMIN;
    return v;
  endfunction

  function automatic longint gain_mul(input longint a, input longint unsigned g);
    logic [127:0] p;
    longint unsigned m;
    m = (a < 0) ? longint'(-a) : longint'(a);
    if (a == -64'sd9223372036854775807 - 1) m = 64'h8000_0000_0000_0000;
    p = {64'd0, m} * {64'd0, g};
    p = p >> FRAC_BITS;
    if (p > 128'(VMAX)) return (a < 0) ? VMIN : VMAX;
    return (a < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic volt_word_t predict_volts(input ctl_word_t w);
    volt_word_t r;
    longint ed, eq, bd, bq, lim, pd, pq, lo, hi, vd, vq;
    longint unsigned md, mq, n, od, oq;
    bit lim_hit;
    r = '0;
    if (w.command == CMD_CLEAR) begin
      acc_d = 0;
      acc_q = 0;
      return r;
    end
    ed = longint'(signed'(w.err_d));
    eq = longint'(signed'(w.err_q));
    bd = longint'(signed'(w.bemf_d));
    bq = longint'(signed'(w.bemf_q));
    lim = longint'(w.volt_limit);
    pd = gain_mul(ed, kp);
    pq = gain_mul(eq, kp);
    acc_d = clip(acc_d + gain_mul(pd, ki));
    acc_q = clip(acc_q + gain_mul(pq, ki));
    if (pq > 0) begin
      lo = clip(-lim + pq - bq);
      hi = clip(lim - pq - bq);
    end else begin
      lo = clip(-lim - pq - bq);
      hi = clip(lim + pq - bq);
    end
    if (lo > 0) lo = 0;
    if (hi < 0) hi = 0;
    if (acc_q > hi) acc_q = hi;
    if (acc_q < lo) acc_q = lo;
    vd = clip(pd + bd + acc_d);
    vq = clip(pq + bq + acc_q);
    md = (vd < 0) ? -vd : vd;
    mq = (vq < 0) ? -vq : vq;
    lim_hit = 1'b0;
    if (md >= 64'h8000_0000 || mq >= 64'h8000_0000) begin
      lim_hit = 1'b1;
      while (md >= 64'h8000_0000 || mq >= 64'h8000_0000) begin
        md >>= 1;
        mq >>= 1;
      end
    end else if (md * md + mq * mq > longint'(lim) * lim) begin
      lim_hit = 1'b1;
    end
    if (lim_hit) begin
      n = root_floor(md * md + mq * mq);
      if (n == 0) n = 1;
      od = (md * lim) / n;
      oq = (mq * lim) / n;
      vd = (vd < 0) ? -longint'(od) : longint'(od);
      vq = (vq < 0) ? -longint'(oq) : longint'(oq);
    end
    r.volt_d = vd[31:0];
    r.volt_q = vq[31:0];
    r.limited = lim_hit;
    return r;
  endfunction

  // driver: present words at the falling edge
  always @(negedge clk) begin
    if (!rst) begin
      // hold the offered word until it has been taken
      if (sent == offered) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0 && !hold_sender) begin
          command <= pending_q[0].command;
          err_d <= pending_q[0].err_d;
          err_q <= pending_q[0].err_q;
          bemf_d <= pending_q[0].bemf_d;
          bemf_q <= pending_q[0].bemf_q;
          volt_limit <= pending_q[0].volt_limit;
          in_valid <= 1'b1;
          offered <= offered + 1;
          if (!quiet && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 15);
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (long_hold_req && long_hold == 0) begin
        long_hold <= 400;
        out_stall <= 1'b1;
      end else if (long_hold > 1) begin
        long_hold <= long_hold - 1;
      end else if (long_hold == 1) begin
        long_hold <= 0;
        out_stall <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= (out_gap > 1);
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(1, 15);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor: sample at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (in_valid && !in_stall) begin
        expected_volts.push_back(predict_volts(pending_q.pop_front()));
        sent <= sent + 1;
      end
      if (out_valid && !out_stall) begin
        if (expected_volts.size() == 0) begin
          $error("result word with no expectation waiting");
          errors++;
        end else begin
          volt_word_t e;
          e = expected_volts.pop_front();
          if (volt_d !== e.volt_d) begin
            $error("volt_d expected %h actual %h", e.volt_d, volt_d);
            errors++;
          end
          if (volt_q !== e.volt_q) begin
            $error("volt_q expected %h actual %h", e.volt_q, volt_q);
            errors++;
          end
          if (limited !== e.limited) begin
            $error("limited expected %b actual %b", e.limited, limited);
            errors++;
          end
          checked <= checked + 1;
          if (e.limited) limited_seen <= limited_seen + 1;
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("dq_current_pi_with_voltage_limit verification failed");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(int'($urandom_range(0, 131072)) - 65536);
      3: return 32'(int'($urandom_range(0, 16777216)) - 8388608);
      4: return '0;
      default: return $urandom();
    endcase
  endfunction

  function automatic ctl_word_t rand_word();
    ctl_word_t w;
    w.command = ($urandom_range(0, 19) == 0) ? CMD_CLEAR : CMD_STEP;
    w.err_d = rand_val();
    w.err_q = rand_val();
    w.bemf_d = rand_val();
    w.bemf_q = rand_val();
    case ($urandom_range(0, 3))
      0: w.volt_limit = 31'h7FFF_FFFF;
      1: w.volt_limit = 31'($urandom_range(0, 2000000));
      default: w.volt_limit = 31'($urandom());
    endcase
    return w;
  endfunction

  function automatic ctl_word_t mk(input logic c, input logic [31:0] a, b, d, q,
                                   input logic [30:0] l);
    ctl_word_t w;
    w.command = c; w.err_d = a; w.err_q = b; w.bemf_d = d; w.bemf_q = q;
    w.volt_limit = l;
    return w;
  endfunction

  task automatic drain();
    while (pending_q.size() > 0 || expected_volts.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_gain(input logic idx, input logic [31:0] val);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(negedge clk);
    wr_en <= 1'b0;
    if (idx == REG_PROP_GAIN) kp = val; else ki = val;
  endtask

  task automatic random_phase(input int count);
    repeat (count) pending_q.push_back(rand_word());
    drain();
  endtask

  initial begin
    kp = PROP_GAIN_RESET;
    ki = INTEG_GAIN_RESET;
    acc_d = 0;
    acc_q = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, clear, limiting, clamp on both signs of P_q
    pending_q.push_back(mk(CMD_STEP, 32'h0001_0000, 32'h0002_0000, 0, 0, 31'h0010_0000));
    pending_q.push_back(mk(CMD_STEP, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
    pending_q.push_back(mk(CMD_STEP, 32'h8000_0000, 32'h8000_0000,
                           32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF));
    pending_q.push_back(mk(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF));
    pending_q.push_back(mk(CMD_STEP, 32'h0003_0000, 32'h0004_0000, 0, 0, 31'h0005_0000));
    pending_q.push_back(mk(CMD_STEP, 32'h0003_0000, 32'h0004_0000, 0, 0, 31'h0001_0000));
    pending_q.push_back(mk(CMD_STEP, 32'h0001_0000, 32'hFFFF_0000, 0, 32'h0002_0000, 0));
    pending_q.push_back(mk(CMD_STEP, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(CMD_STEP, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 1));
    pending_q.push_back(mk(CMD_STEP, 32'hFFF0_0000, 32'h0010_0000, 32'h0010_0000,
                           32'hFFF0_0000, 31'h0002_0000));
    pending_q.push_back(mk(CMD_CLEAR, 0, 0, 0, 0, 0));
    drain();

    write_gain(REG_PROP_GAIN, 32'hFFFF_FFFF);
    write_gain(REG_INTEG_STEP_GAIN, 32'hFFFF_FFFF);
    pending_q.push_back(mk(CMD_STEP, 32'h0000_0100, 32'hFFFF_FF00, 0, 0, 31'h7FFF_FFFF));
    pending_q.push_back(mk(CMD_STEP, 32'h0001_0000, 32'h0001_0000, 0, 0, 31'h0100_0000));
    pending_q.push_back(mk(CMD_CLEAR, 0, 0, 0, 0, 0));
    drain();
    write_gain(REG_PROP_GAIN, 32'd0);
    write_gain(REG_INTEG_STEP_GAIN, 32'd0);
    pending_q.push_back(mk(CMD_STEP, 32'h7FFF_FFFF, 32'h8000_0000,
                           32'h0001_0000, 32'hFFFF_0000, 31'h0000_8000));
    drain();

    write_gain(REG_PROP_GAIN, PROP_GAIN_RESET);
    write_gain(REG_INTEG_STEP_GAIN, INTEG_GAIN_RESET);
    random_phase(300);

    // long receiver hold while the sender keeps offering
    long_hold_req = 1'b1;
    repeat (40) pending_q.push_back(rand_word());
    @(posedge clk);
    long_hold_req = 1'b0;
    drain();

    write_gain(REG_PROP_GAIN, 32'h0004_0000);
    write_gain(REG_INTEG_STEP_GAIN, 32'h0000_4000);

    // sender pauses mid-stream until every result is back, then continues
    repeat (300) pending_q.push_back(rand_word());
    while (pending_q.size() > 150) @(posedge clk);
    hold_sender = 1'b1;
    while (expected_volts.size() > 0 || sent != offered) @(posedge clk);
    hold_sender = 1'b0;
    drain();

    write_gain(REG_PROP_GAIN, $urandom());
    write_gain(REG_INTEG_STEP_GAIN, $urandom_range(0, 65536));
    random_phase(300);

    write_gain(REG_PROP_GAIN, $urandom_range(0, 32'h0002_0000));
    write_gain(REG_INTEG_STEP_GAIN, $urandom());
    random_phase(250);

    quiet = 1'b1;
    random_phase(150);

    $display("covered %0d words checked, %0d limited, gains swept through both extremes",
             checked, limited_seen);
    if (errors == 0) begin
      $display("dq_current_pi_with_voltage_limit verification clean");
    end else begin
      $display("dq_current_pi_with_voltage_limit verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/dqcpi_pkg.sv
sv/dqcpi_ctrl.sv
sv/dqcpi_dp.sv
sv/dq_current_pi_with_voltage_limit.sv
sim/tb_dq_current_pi_with_voltage_limit.sv
